>>> rtl/lqcm_pkg.sv
// Package of shared types, codes and the keyword table for the line queue command matcher.
package lqcm_pkg;

   localparam int KW_COUNT = 8;
   localparam int KW_MAX = 23;
   localparam int KW_BITS = KW_MAX * 8;
   localparam int KW_POS_W = 5;
   localparam int KW_IDX_W = 3;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_FETCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_MATCH   = 2'd0,
      STATUS_NOMATCH = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_REPORT
   } seq_state_type;

   // Control of the character match unit for one cycle
   typedef struct packed {
      logic                clear;
      logic                valid;
      logic [KW_POS_W-1:0] pos;
   } cmp_ctrl_type;

   // Keywords, right-justified: the last character sits in the low byte
   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      KW_BITS'({"led_all", "_on"}),
      KW_BITS'({"led_all", "_off"}),
      KW_BITS'({"shift_left", "_led_on"}),
      KW_BITS'({"shift_right", "_led_on"}),
      KW_BITS'({"shift_left", "_keep", "_led_on"}),
      KW_BITS'({"shift_right", "_keep", "_led_on"}),
      KW_BITS'({"flower", "_on"}),
      KW_BITS'({"flower", "_off"})
   };

   localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{
      5'd10, 5'd11, 5'd17, 5'd18, 5'd22, 5'd23, 5'd9, 5'd10
   };

   // Character n of keyword k; zero past the keyword's end
   function automatic logic [7:0] kw_char(input int unsigned k, input logic [KW_POS_W-1:0] n);
      logic [KW_POS_W-1:0] idx;
      logic [7:0]          ch;
      idx = KW_LEN[k] - n - 5'd1;
      ch = 8'h00;
      if (n < KW_LEN[k]) begin
         ch = KW_TEXT[k][{idx, 3'b000} +: 8];
      end
      return ch;
   endfunction

endpackage

>>> rtl/lqcm_line_store.sv
// Line slot memories: character store and per-slot length, each with a registered read.
module lqcm_line_store import lqcm_pkg::*; #(
   parameter int SLOT_W = 3,
   parameter int POS_W = 5
) (
   input  logic              clock,
   input  logic              byte_we,
   input  logic [SLOT_W-1:0] byte_slot,
   input  logic [POS_W-1:0]  byte_pos,
   input  logic [7:0]        byte_data,
   input  logic              len_we,
   input  logic [SLOT_W-1:0] len_slot,
   input  logic [POS_W-1:0]  len_data,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic [POS_W-1:0]  rd_pos,
   output logic [7:0]        rd_byte,
   output logic [POS_W-1:0]  rd_len
);

   localparam int DEPTH = (2 ** SLOT_W) * (2 ** POS_W);
   localparam int LDEPTH = 2 ** SLOT_W;

   logic [7:0]       char_mem [DEPTH];
   logic [POS_W-1:0] len_mem [LDEPTH];
   logic [7:0]       rd_byte_ff;
   logic [POS_W-1:0] rd_len_ff;

   // Write and read the character store
   always_ff @(posedge clock) begin
      if (byte_we) begin
         char_mem[{byte_slot, byte_pos}] <= byte_data;
      end
      rd_byte_ff <= char_mem[{rd_slot, rd_pos}];
   end

   // Write and read the slot lengths
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_slot] <= len_data;
      end
      rd_len_ff <= len_mem[rd_slot];
   end

   assign rd_byte = rd_byte_ff;
   assign rd_len = rd_len_ff;

endmodule

>>> rtl/lqcm_char_matcher.sv
// Shared character match unit: checks one stored character against every keyword column.
module lqcm_char_matcher import lqcm_pkg::*; #(
   parameter int POS_W = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  cmp_ctrl_type        ctrl,
   input  logic [7:0]          line_char,
   input  logic [POS_W-1:0]    line_len,
   output logic [KW_COUNT-1:0] alive
);

   logic [KW_COUNT-1:0] alive_ff;
   logic [KW_COUNT-1:0] alive_in;
   logic [POS_W-1:0]    pos_ext;

   assign pos_ext = POS_W'(ctrl.pos);

   // Drop a keyword on a mismatch or when the line ends before it
   always_comb begin
      alive_in = alive_ff;
      if (ctrl.clear) begin
         alive_in = '1;
      end else if (ctrl.valid) begin
         for (int unsigned k = 0; k < KW_COUNT; k++) begin
            if (ctrl.pos < KW_LEN[k]) begin
               if (pos_ext >= line_len || line_char != kw_char(k, ctrl.pos)) begin
                  alive_in[k] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '1;
      end else begin
         alive_ff <= alive_in;
      end
   end

   assign alive = alive_ff;

endmodule

>>> rtl/line_queue_command_matcher_unit.sv
// Top level: line queue control, fetch sequencer and result register.
//
//  channel  | ports                                              | transfer
//  ---------+----------------------------------------------------+--------------------------
//  request  | start, busy, req_operation, req_rx_byte             | start high, busy low
//  result   | rsp_valid, rsp_status, rsp_command_index,           | rsp_valid high, one cycle
//           | rsp_lines_lost                                     |
//
// A received byte gives no result. A fetch on an empty queue leaves busy low; its
// result shows in the next cycle. A fetch of a queued line holds busy through the
// scan, flush and report states: scan reads characters through the single memory
// read port up to the longest keyword's length, flush does the last compare and
// report loads the result, which shows as busy falls. Reset is synchronous and
// clears the queue pointers, counters and flags. The receiver cannot stall results.
module line_queue_command_matcher_unit import lqcm_pkg::*; #(
   parameter int SLOT_COUNT = 8,
   parameter int LINE_LENGTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [KW_IDX_W-1:0] rsp_command_index,
   output logic                rsp_lines_lost
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int POS_W = $clog2(LINE_LENGTH);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOT_COUNT);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LENGTH - 1);
   localparam logic [KW_POS_W-1:0] SCAN_LAST = KW_POS_W'(KW_MAX - 1);

   seq_state_type state_ff, state_in;

   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]    waiting_ff, waiting_in;
   logic [POS_W-1:0]    char_pos_ff, char_pos_in;
   logic                discard_ff, discard_in;
   logic                lost_ff, lost_in;
   logic [KW_POS_W-1:0] pos_ff, pos_in;
   logic [KW_POS_W-1:0] dpos_ff, dpos_in;
   logic                dvalid_ff, dvalid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [KW_IDX_W-1:0] index_ff, index_in;
   logic                rsp_lost_ff, rsp_lost_in;

   logic                accept;
   logic                take_byte;
   logic                take_fetch;
   logic                is_newline;
   logic                line_start_full;
   logic                drop_line;
   logic                byte_we;
   logic                len_we;
   logic                report;
   logic [7:0]          rd_byte;
   logic [POS_W-1:0]    rd_len;
   logic [KW_COUNT-1:0] alive;
   cmp_ctrl_type        cmp_ctrl;
   status_type          match_status;
   logic [KW_IDX_W-1:0] match_index;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign take_byte = accept && (op_type'(req_operation) == OP_BYTE);
   assign take_fetch = accept && (op_type'(req_operation) == OP_FETCH);
   assign is_newline = (req_rx_byte == NEWLINE_CHAR);
   assign line_start_full = !discard_ff && (char_pos_ff == '0) && (waiting_ff == CNT_FULL);
   assign drop_line = discard_ff || line_start_full;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take_fetch && waiting_ff != '0) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pos_ff == SCAN_LAST) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_REPORT;
         end
         S_REPORT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs: read position, compare control, report
   always_comb begin
      pos_in = pos_ff;
      dvalid_in = 1'b0;
      dpos_in = pos_ff;
      cmp_ctrl.clear = 1'b0;
      report = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pos_in = '0;
            cmp_ctrl.clear = take_fetch;
         end
         S_SCAN: begin
            dvalid_in = 1'b1;
            pos_in = pos_ff + 1'b1;
         end
         S_FLUSH: begin
            dvalid_in = 1'b0;
         end
         S_REPORT: begin
            report = 1'b1;
         end
         default: begin
            pos_in = '0;
         end
      endcase
      cmp_ctrl.valid = dvalid_ff;
      cmp_ctrl.pos = dpos_ff;
   end

   // Pick the first surviving keyword
   always_comb begin
      match_index = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive[k]) begin
            match_index = KW_IDX_W'(k);
         end
      end
      match_status = (alive != '0) ? STATUS_MATCH : STATUS_NOMATCH;
   end

   // Advance the queue on received bytes and finished fetches
   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in = read_slot_ff;
      waiting_in = waiting_ff;
      char_pos_in = char_pos_ff;
      discard_in = discard_ff;
      lost_in = lost_ff;
      byte_we = 1'b0;
      len_we = 1'b0;
      if (take_byte) begin
         if (line_start_full) begin
            lost_in = 1'b1;
         end
         if (is_newline) begin
            if (!drop_line) begin
               len_we = 1'b1;
               write_slot_in = (write_slot_ff == SLOT_LAST) ? '0 : write_slot_ff + 1'b1;
               waiting_in = waiting_ff + 1'b1;
            end
            discard_in = 1'b0;
            char_pos_in = '0;
         end else begin
            discard_in = drop_line;
            if (!drop_line && char_pos_ff < POS_LIMIT) begin
               byte_we = 1'b1;
               char_pos_in = char_pos_ff + 1'b1;
            end
         end
      end
      if ((take_fetch && waiting_ff == '0) || report) begin
         lost_in = 1'b0;
      end
      if (report) begin
         read_slot_in = (read_slot_ff == SLOT_LAST) ? '0 : read_slot_ff + 1'b1;
         waiting_in = waiting_ff - 1'b1;
      end
   end

   // Load the result register
   always_comb begin
      rsp_valid_in = 1'b0;
      status_in = status_ff;
      index_in = index_ff;
      rsp_lost_in = rsp_lost_ff;
      if (take_fetch && waiting_ff == '0) begin
         rsp_valid_in = 1'b1;
         status_in = STATUS_EMPTY;
         index_in = '0;
         rsp_lost_in = lost_ff;
      end else if (report) begin
         rsp_valid_in = 1'b1;
         status_in = match_status;
         index_in = match_index;
         rsp_lost_in = lost_ff;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         write_slot_ff <= '0;
         read_slot_ff <= '0;
         waiting_ff <= '0;
         char_pos_ff <= '0;
         discard_ff <= 1'b0;
         lost_ff <= 1'b0;
         pos_ff <= '0;
         dvalid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff <= read_slot_in;
         waiting_ff <= waiting_in;
         char_pos_ff <= char_pos_in;
         discard_ff <= discard_in;
         lost_ff <= lost_in;
         pos_ff <= pos_in;
         dvalid_ff <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      dpos_ff <= dpos_in;
      status_ff <= status_in;
      index_ff <= index_in;
      rsp_lost_ff <= rsp_lost_in;
   end

   lqcm_line_store #(
      .SLOT_W(SLOT_W),
      .POS_W(POS_W)
   ) u_store (
      .clock    (clock),
      .byte_we  (byte_we),
      .byte_slot(write_slot_ff),
      .byte_pos (char_pos_ff),
      .byte_data(req_rx_byte),
      .len_we   (len_we),
      .len_slot (write_slot_ff),
      .len_data (char_pos_ff),
      .rd_slot  (read_slot_ff),
      .rd_pos   (POS_W'(pos_ff)),
      .rd_byte  (rd_byte),
      .rd_len   (rd_len)
   );

   lqcm_char_matcher #(
      .POS_W(POS_W)
   ) u_matcher (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cmp_ctrl),
      .line_char(rd_byte),
      .line_len (rd_len),
      .alive    (alive)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_command_index = index_ff;
   assign rsp_lines_lost = rsp_lost_ff;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_queue_command_matcher_unit with random line traffic.
module tb_top import lqcm_pkg::*; ();

   localparam int SLOTS        = 8;
   localparam int LINE_LEN     = 32;
   localparam int ITEM_TARGET  = 850;
   localparam int IDLE_PCT     = 19;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 30;
   localparam int SHOWN_ERRORS = 10;

   typedef struct {
      op_type     op;
      logic [7:0] data;
      bit         drain;
   } rx_cmd_type;

   typedef struct {
      status_type          status;
      logic [KW_IDX_W-1:0] index;
      logic                lost;
   } fetch_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = OP_BYTE;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [KW_IDX_W-1:0] rsp_command_index;
   logic                rsp_lines_lost;

   // Keyword text, built from the package table before any traffic
   string keywords [KW_COUNT];

   // Pending commands and fetch results still owed by the block
   rx_cmd_type       cmd_queue [$];
   fetch_result_type pending_results [$];
   bit               drain_next = 1'b0;

   // Shadow copy of the line ring
   logic [7:0] line_mem [SLOTS][LINE_LEN];
   int         slot_len [SLOTS];
   int         wr_slot = 0;
   int         rd_slot = 0;
   int         lines_waiting = 0;
   int         char_pos = 0;
   bit         discarding = 1'b0;
   bit         lost_pending = 1'b0;

   // Run statistics
   int error_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int quiet_cycles = 0;
   int bytes_seen = 0;
   int lines_queued = 0;
   int lines_dropped = 0;
   int clipped_chars = 0;
   int lost_reports = 0;
   int status_seen [3] = '{0, 0, 0};
   int kw_hits [KW_COUNT] = '{default: 0};

   line_queue_command_matcher_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_command_index (rsp_command_index),
      .rsp_lines_lost    (rsp_lines_lost)
   );

   always #5 clock = ~clock;

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= SHOWN_ERRORS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endfunction

   // Spell out keyword k from the package table
   function automatic string kw_string(int unsigned k);
      string s;
      s = "";
      for (int n = 0; n < int'(KW_LEN[k]); n++) begin
         s = $sformatf("%s%c", s, kw_char(k, KW_POS_W'(n)));
      end
      return s;
   endfunction

   function automatic bit line_begins_with(int slot, string kw);
      for (int n = 0; n < kw.len(); n++) begin
         if (n >= slot_len[slot]) return 1'b0;
         if (line_mem[slot][n] != kw[n]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advance the shadow line ring by one accepted transfer
   task automatic model_line_queue(input op_type op, input logic [7:0] data);
      fetch_result_type res;
      if (op == OP_BYTE) begin
         bytes_seen++;
         // A new line on a full ring is thrown away up to its newline
         if (!discarding && char_pos == 0 && lines_waiting >= SLOTS) begin
            discarding = 1'b1;
            lost_pending = 1'b1;
            lines_dropped++;
         end
         if (data == NEWLINE_CHAR) begin
            if (discarding) begin
               discarding = 1'b0;
            end else begin
               slot_len[wr_slot] = char_pos;
               wr_slot = (wr_slot + 1) % SLOTS;
               lines_waiting++;
               lines_queued++;
            end
            char_pos = 0;
         end else if (!discarding) begin
            if (char_pos < LINE_LEN - 1) begin
               line_mem[wr_slot][char_pos] = data;
               char_pos++;
            end else begin
               clipped_chars++;
            end
         end
      end else begin
         res.status = STATUS_EMPTY;
         res.index = '0;
         res.lost = lost_pending;
         if (lines_waiting > 0) begin
            res.status = STATUS_NOMATCH;
            // First keyword in table order wins
            for (int k = 0; k < KW_COUNT; k++) begin
               if (res.status == STATUS_NOMATCH && line_begins_with(rd_slot, keywords[k])) begin
                  res.status = STATUS_MATCH;
                  res.index = KW_IDX_W'(k);
                  kw_hits[k]++;
               end
            end
            rd_slot = (rd_slot + 1) % SLOTS;
            lines_waiting--;
         end
         if (res.lost) lost_reports++;
         status_seen[res.status]++;
         lost_pending = 1'b0;
         pending_results.push_back(res);
      end
   endtask

   task automatic add_cmd(input op_type op, input logic [7:0] data);
      rx_cmd_type c;
      c.op = op;
      c.data = data;
      c.drain = drain_next;
      drain_next = 1'b0;
      cmd_queue.push_back(c);
   endtask

   task automatic add_byte(input logic [7:0] b);
      add_cmd(OP_BYTE, b);
   endtask

   // The byte field is ignored on a fetch; drive it random anyway
   task automatic add_fetch();
      add_cmd(OP_FETCH, 8'($urandom_range(0, 255)));
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Any byte except newline
   function automatic logic [7:0] text_char();
      int b;
      b = $urandom_range(0, 254);
      if (b >= NEWLINE_CHAR) b++;
      return 8'(b);
   endfunction

   // One newline-terminated line: mostly keywords, with near misses and long lines
   task automatic add_random_line();
      int         kind;
      int         pos;
      string      kw;
      logic [7:0] b;
      kw = keywords[$urandom_range(0, KW_COUNT - 1)];
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: add_text(kw);
         4: begin
            add_text(kw);
            repeat ($urandom_range(1, 8)) add_byte(text_char());
         end
         5: begin
            // corrupt one character, often with a zero byte
            pos = $urandom_range(0, kw.len() - 1);
            for (int i = 0; i < kw.len(); i++) begin
               if (i == pos) begin
                  b = ($urandom_range(0, 1) == 1) ? 8'h00 : text_char();
                  if (b == kw[i]) b = 8'h00;
                  add_byte(b);
               end else begin
                  add_byte(kw[i]);
               end
            end
         end
         6: begin
            pos = $urandom_range(0, kw.len() - 1);
            for (int i = 0; i < pos; i++) add_byte(kw[i]);
         end
         7: repeat ($urandom_range(0, 12)) add_byte(text_char());
         8: begin
            add_text(kw);
            repeat ($urandom_range(LINE_LEN - 1 - kw.len(), LINE_LEN + 12 - kw.len()))
               add_byte(text_char());
         end
         default: repeat ($urandom_range(LINE_LEN - 2, LINE_LEN + 8)) add_byte(text_char());
      endcase
      add_byte(NEWLINE_CHAR);
   endtask

   // Driver: present queued commands, hold each until the transfer
   always @(posedge clock) begin : drive_requests
      rx_cmd_type nxt;
      bit         hold;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            model_line_queue(op_type'(req_operation), req_rx_byte);
            accepted_count++;
         end
         if (!start || !busy) begin
            hold = (cmd_queue.size() == 0)
                   || (cmd_queue[0].drain && pending_results.size() != 0)
                   || ((accepted_count < 300 || accepted_count >= 480)
                       && $urandom_range(0, 99) < IDLE_PCT);
            if (hold) begin
               start <= 1'b0;
            end else begin
               nxt = cmd_queue.pop_front();
               start <= 1'b1;
               req_operation <= nxt.op;
               req_rx_byte <= nxt.data;
            end
         end
      end
   end

   // Monitor: check each result strobe against the oldest prediction; run the watchdog
   always @(posedge clock) begin : check_results
      fetch_result_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("line_queue_command_matcher_unit verification failed");
            $finish;
         end else if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               note_error($sformatf("unexpected result: status %0d index %0d lost %0d",
                                    rsp_status, rsp_command_index, rsp_lines_lost));
            end else begin
               want = pending_results.pop_front();
               result_count++;
               if (rsp_status !== want.status || rsp_command_index !== want.index ||
                   rsp_lines_lost !== want.lost) begin
                  note_error($sformatf(
                     "fetch %0d: expected status %0d index %0d lost %0d, got %0d %0d %0d",
                     result_count, want.status, want.index, want.lost,
                     rsp_status, rsp_command_index, rsp_lines_lost));
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int r;
      int kw_covered;
      int total_items;
      for (int k = 0; k < KW_COUNT; k++) keywords[k] = kw_string(k);

      // empty fetch, one exact keyword, then fill the ring with empty lines
      add_fetch();
      add_text(keywords[0]);
      add_byte(NEWLINE_CHAR);
      add_fetch();
      repeat (SLOTS) add_byte(NEWLINE_CHAR);
      // ring full: this line is dropped, and a fetch mid-drop does not revive it
      add_byte("a");
      add_fetch();
      add_byte(8'hFF);
      add_byte(NEWLINE_CHAR);

      // wait for every result before the random traffic starts
      drain_next = 1'b1;
      while (cmd_queue.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 2) drain_next = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            add_random_line();
            if ($urandom_range(0, 99) < 85) add_fetch();
         end else if (r < 75) begin
            repeat ($urandom_range(1, 2)) add_fetch();
         end else if (r < 83) begin
            // burst of lines to overrun the ring, then drain it
            repeat ($urandom_range(6, 11)) add_random_line();
            if ($urandom_range(0, 1) == 1) begin
               repeat ($urandom_range(1, 4)) add_byte(text_char());
               add_fetch();
               repeat ($urandom_range(0, 4)) add_byte(text_char());
               add_byte(NEWLINE_CHAR);
            end
            repeat ($urandom_range(4, 10)) add_fetch();
         end else if (r < 93) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
         end else begin
            // fetch in the middle of collecting a keyword line
            add_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
            add_fetch();
            add_byte(NEWLINE_CHAR);
            add_fetch();
         end
      end
      // trim the overshoot of the last step
      while (cmd_queue.size() > ITEM_TARGET) void'(cmd_queue.pop_back());
      total_items = cmd_queue.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         note_error($sformatf("%0d results never arrived", pending_results.size()));
      end

      kw_covered = 0;
      foreach (kw_hits[k]) if (kw_hits[k] != 0) kw_covered++;
      $display("Covered %0d transfers (%0d bytes), %0d fetches:",
               accepted_count, bytes_seen, result_count);
      $display("  %0d matched, %0d no match, %0d empty",
               status_seen[STATUS_MATCH], status_seen[STATUS_NOMATCH],
               status_seen[STATUS_EMPTY]);
      $display("Lines queued %0d, dropped on full ring %0d, clipped chars %0d,",
               lines_queued, lines_dropped, clipped_chars);
      $display("  lost reports %0d, keywords hit %0d of %0d",
               lost_reports, kw_covered, KW_COUNT);
      if (error_count == 0) begin
         $display("line_queue_command_matcher_unit verification clean");
      end else begin
         $display("Mismatches: %0d", error_count);
         $display("line_queue_command_matcher_unit verification failed");
      end
      $finish;
   end

endmodule
